// File: design/epoch_anti_replay_window_assert.svh
// Assertion macros shared by the anti-replay window RTL.
// Checks are live in simulation; the SYNTHESIS build gets empty bodies.
// Users must have aclk and aresetn in scope.
`ifndef EPOCH_ANTI_REPLAY_WINDOW_ASSERT_SVH
`define EPOCH_ANTI_REPLAY_WINDOW_ASSERT_SVH

`ifndef SYNTHESIS
`define EARW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define EARW_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (conseq)) \
        else $error(msg);
`else
`define EARW_ASSERT(label, prop, msg)
`define EARW_ASSERT_NEXT(label, cond, conseq, msg)
`endif

`endif

// File: design/earw_pkg.sv
// Shared types and constants for the epoch anti-replay window.
// Used by earw_epoch, earw_window and epoch_anti_replay_window.
package earw_pkg;

    localparam int HEADER_BYTES = 6;
    localparam int TAG_BYTES    = 16;
    localparam int MAX_LENGTH   = 2048;
    localparam int WINDOW_SIZE  = 64;
    localparam int WIN_IDX_W    = $clog2(WINDOW_SIZE);

    localparam int LEN_W      = 12;
    localparam int MIN_LENGTH = HEADER_BYTES + TAG_BYTES;
    localparam logic [LEN_W-1:0] MIN_LEN   = LEN_W'(MIN_LENGTH);
    localparam logic [31:0]      MAX_LEN32 = 32'(MAX_LENGTH);

    localparam int IN_FIELDS_W  = 8 + 32 + 1 + 1 + 4 + LEN_W + 1;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 + 32 + 1 + 4 + LEN_W + 3 * 32;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_ACCEPT    = 3'd0,
        ST_MALFORMED = 3'd1,
        ST_AUTH_FAIL = 3'd2,
        ST_STALE     = 3'd3,
        ST_REPLAY    = 3'd4
    } status_t;

    // Input word, lowest field last
    typedef struct packed {
        logic [IN_TDATA_W-IN_FIELDS_W-1:0] pad;
        logic             tag_ok;
        logic [LEN_W-1:0] datagram_length;
        logic [3:0]       traffic_class;
        logic             flag_auth;
        logic             flag_session;
        logic [31:0]      seq_number;
        logic [7:0]       epoch_low;
    } in_word_t;

    // Result word, lowest field last
    typedef struct packed {
        logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] pad;
        logic [31:0]      replay_count;
        logic [31:0]      stale_epoch_count;
        logic [31:0]      auth_fail_count;
        logic [LEN_W-1:0] payload_length;
        logic [3:0]       class_out;
        logic             epoch_adopted;
        logic [31:0]      full_epoch;
        status_t          status;
    } out_word_t;

    typedef struct packed {
        logic [31:0] full_epoch;
        logic        stale;
        logic        newer;
    } epoch_info_t;

    typedef struct packed {
        logic restart;
        logic slide;
    } win_ctl_t;

endpackage

// File: design/earw_epoch.sv
// Current receive epoch register and full-epoch reconstruction from the low byte.
// Depends on earw_pkg.
module earw_epoch
    import earw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  epoch_low,
    input  logic        adopt,
    output epoch_info_t info,
    output logic [31:0] cur_epoch
);

    logic [31:0]       cur_epoch_reg;
    logic signed [9:0] delta;
    logic [23:0]       upper;

    assign delta = $signed({2'b00, epoch_low}) - $signed({2'b00, cur_epoch_reg[7:0]});

    // Pick the epoch nearest the current one: move up or down one byte page
    always_comb begin
        upper      = cur_epoch_reg[31:8];
        info.stale = (delta < 10'sd0);
        info.newer = (delta > 10'sd0);
        if (delta < -10'sd128) begin
            upper      = cur_epoch_reg[31:8] + 24'd1;
            info.stale = 1'b0;
            info.newer = 1'b1;
        end else if (delta > 10'sd128) begin
            upper      = cur_epoch_reg[31:8] - 24'd1;
            info.stale = 1'b1;
            info.newer = 1'b0;
        end
        info.full_epoch = {upper, epoch_low};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_epoch_reg <= 32'd0;
        end else if (adopt) begin
            cur_epoch_reg <= info.full_epoch;
        end
    end

    assign cur_epoch = cur_epoch_reg;

endmodule

// File: design/earw_window.sv
// Sliding replay bitmap: top sequence number plus one bit per recent sequence.
// Depends on earw_pkg.
module earw_window
    import earw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] seq,
    input  win_ctl_t    ctl,
    output logic        replay
);

    localparam logic [WINDOW_SIZE-1:0] BIT0 = {{(WINDOW_SIZE-1){1'b0}}, 1'b1};
    localparam logic [31:0]            WIN32 = 32'(WINDOW_SIZE);

    logic [31:0]            top_reg, top_next;
    logic [WINDOW_SIZE-1:0] bits_reg, bits_next;
    logic [32:0]            ahead;
    logic [31:0]            behind;
    logic                   is_ahead, far_ahead, too_old;

    assign ahead     = {1'b0, seq} - {1'b0, top_reg};
    assign behind    = top_reg - seq;
    assign is_ahead  = !ahead[32] && (ahead[31:0] != 32'd0);
    assign far_ahead = (ahead[31:0] >= WIN32);
    assign too_old   = (behind >= WIN32);
    assign replay    = !is_ahead && (too_old || bits_reg[behind[WIN_IDX_W-1:0]]);

    always_comb begin
        top_next  = top_reg;
        bits_next = bits_reg;
        if (ctl.restart) begin
            top_next  = seq;
            bits_next = BIT0;
        end else if (ctl.slide && is_ahead) begin
            // advance the top, drop bits that fall off the far end
            top_next  = seq;
            bits_next = far_ahead ? BIT0 : ((bits_reg << ahead[WIN_IDX_W-1:0]) | BIT0);
        end else if (ctl.slide && !replay) begin
            bits_next = bits_reg | (BIT0 << behind[WIN_IDX_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg  <= 32'd0;
            bits_reg <= '0;
        end else begin
            top_reg  <= top_next;
            bits_reg <= bits_next;
        end
    end

endmodule

// File: design/epoch_anti_replay_window.sv
// Epoch-aware anti-replay check for received datagram headers. The block takes one
// header word per cycle and returns one result word for each: the word is captured
// in an input register, classified and checked against the 64-entry replay window in
// one pass of logic, and the verdict lands in the result register together with the
// updated epoch, window and counters, so the next word already sees them. Sustained
// rate is one word per cycle as long as the result side keeps taking words. Reset
// clears the session, valid flags, epoch, window and counters, not the data registers.
// Depends on earw_pkg, earw_epoch, earw_window and the assertion macro header.
`include "epoch_anti_replay_window_assert.svh"

module epoch_anti_replay_window
    import earw_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_wr_data,   // session_established
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [7:0] epoch_low, [39:8] seq_number, [40] flag_session, [41] flag_auth,
    // [45:42] traffic_class, [57:46] datagram_length, [58] tag_ok, [63:59] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [2:0] status, [34:3] full_epoch, [35] epoch_adopted, [39:36] class_out,
    // [51:40] payload_length, [83:52] auth_fail_count, [115:84] stale_epoch_count,
    // [147:116] replay_count, [151:148] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic        session_reg;
    logic        in_valid_reg;
    in_word_t    in_item_reg;
    logic        m_valid_reg;
    out_word_t   out_reg, out_next;
    logic [31:0] auth_total_reg, auth_total_next;
    logic [31:0] stale_total_reg, stale_total_next;
    logic [31:0] replay_total_reg, replay_total_next;

    logic        advance;
    logic        format_ok;
    logic        adopt;
    logic        replay;
    logic [31:0] cur_epoch;
    epoch_info_t ep_info;
    win_ctl_t    win_ctl;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !m_valid_reg || m_tready;

    assign format_ok = session_reg
                    && (in_item_reg.datagram_length >= MIN_LEN)
                    && !(32'(in_item_reg.datagram_length) > MAX_LEN32)
                    && in_item_reg.flag_session
                    && in_item_reg.flag_auth;

    earw_epoch u_epoch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .epoch_low (in_item_reg.epoch_low),
        .adopt     (adopt),
        .info      (ep_info),
        .cur_epoch (cur_epoch)
    );

    earw_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .seq     (in_item_reg.seq_number),
        .ctl     (win_ctl),
        .replay  (replay)
    );

    always_comb begin
        auth_total_next   = auth_total_reg;
        stale_total_next  = stale_total_reg;
        replay_total_next = replay_total_reg;
        win_ctl           = '0;
        adopt             = 1'b0;

        out_next                = '0;
        out_next.status         = ST_MALFORMED;
        out_next.full_epoch     = ep_info.full_epoch;

        priority if (!format_ok) begin
            out_next.full_epoch = 32'd0;
        end else if (ep_info.stale) begin
            out_next.status  = ST_STALE;
            stale_total_next = stale_total_reg + 32'd1;
        end else if (!in_item_reg.tag_ok) begin
            out_next.status = ST_AUTH_FAIL;
            auth_total_next = auth_total_reg + 32'd1;
        end else if (ep_info.newer) begin
            // adopt the newer epoch and restart the window on this sequence
            out_next.status        = ST_ACCEPT;
            out_next.epoch_adopted = 1'b1;
            win_ctl.restart        = advance;
            adopt                  = advance;
        end else if (replay) begin
            out_next.status   = ST_REPLAY;
            replay_total_next = replay_total_reg + 32'd1;
        end else begin
            out_next.status = ST_ACCEPT;
            win_ctl.slide   = advance;
        end

        if (out_next.status == ST_ACCEPT) begin
            out_next.class_out      = in_item_reg.traffic_class;
            out_next.payload_length = in_item_reg.datagram_length - MIN_LEN;
        end

        out_next.auth_fail_count   = auth_total_next;
        out_next.stale_epoch_count = stale_total_next;
        out_next.replay_count      = replay_total_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            session_reg      <= 1'b0;
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            auth_total_reg   <= 32'd0;
            stale_total_reg  <= 32'd0;
            replay_total_reg <= 32'd0;
        end else begin
            if (cfg_wr_en) begin
                session_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg      <= 1'b1;
                auth_total_reg   <= auth_total_next;
                stale_total_reg  <= stale_total_next;
                replay_total_reg <= replay_total_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_word_t'(s_tdata);
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    `EARW_ASSERT(a_stall_only_when_full, !s_tready |-> (in_valid_reg && m_valid_reg && !m_tready), "input stalled without a full pipeline")
    `EARW_ASSERT(a_reject_clears_fields, (m_valid_reg && out_reg.status != ST_ACCEPT) |-> (out_reg.class_out == 4'd0 && out_reg.payload_length == 12'd0 && !out_reg.epoch_adopted), "rejected word carries accept fields")
    `EARW_ASSERT_NEXT(a_adopt_epoch, advance && win_ctl.restart, cur_epoch == $past(out_next.full_epoch), "adopted epoch not taken")
    `EARW_ASSERT_NEXT(a_replay_counted, advance && out_next.status == ST_REPLAY, replay_total_reg == $past(replay_total_reg) + 32'd1, "replay not counted")

endmodule

// File: dv/epoch_anti_replay_window_tb.sv
// Self-checking testbench for epoch_anti_replay_window: directed header table, then random traffic.
// Every result word is checked against an in-bench model of the epoch and replay window state.
// Depends on earw_pkg and the epoch_anti_replay_window RTL.
module epoch_anti_replay_window_tb;
    import earw_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        bit          session;
        in_word_t    word;
        bit          typed;
        status_t     status;
        logic [31:0] epoch;
    } probe_row_t;

    typedef struct {
        bit session;
        int src_idle;
        int rcv_idle;
        int count;
    } phase_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic                   cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // receiver state as the block should hold it
    bit          session_on  = 1'b0;
    logic [31:0] cur_epoch   = '0;
    logic [31:0] win_top     = '0;
    logic [63:0] win_bits    = '0;
    logic [31:0] auth_fails  = '0;
    logic [31:0] stale_hits  = '0;
    logic [31:0] replay_hits = '0;

    out_word_t verdict_q[$];
    out_word_t got_word;
    out_word_t want_word;
    int        src_idle_pct = 23;
    int        rcv_idle_pct = 65;
    int        mismatches   = 0;
    int        quiet_cycles = 0;

    epoch_anti_replay_window dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic out_word_t predict_verdict(input in_word_t w);
        out_word_t   v;
        logic [31:0] epoch;
        logic [31:0] gap;
        int          delta;
        v = '0;
        if (!session_on || w.datagram_length < MIN_LENGTH || w.datagram_length > MAX_LENGTH ||
            !w.flag_session || !w.flag_auth) begin
            v.status = ST_MALFORMED;
        end else begin
            epoch = {cur_epoch[31:8], w.epoch_low};
            delta = int'(w.epoch_low) - int'(cur_epoch[7:0]);
            // pull the low byte to the nearest epoch within +-128
            if (delta < -128) begin
                epoch = epoch + 32'd256;
                delta = delta + 256;
            end else if (delta > 128) begin
                epoch = epoch - 32'd256;
                delta = delta - 256;
            end
            v.full_epoch = epoch;
            if (delta < 0) begin
                stale_hits++;
                v.status = ST_STALE;
            end else if (!w.tag_ok) begin
                auth_fails++;
                v.status = ST_AUTH_FAIL;
            end else if (delta > 0) begin
                cur_epoch       = epoch;
                win_top         = w.seq_number;
                win_bits        = 64'd1;
                v.epoch_adopted = 1'b1;
                v.status        = ST_ACCEPT;
            end else if (w.seq_number > win_top) begin
                gap      = w.seq_number - win_top;
                win_bits = (gap >= WINDOW_SIZE) ? 64'd1 : ((win_bits << gap) | 64'd1);
                win_top  = w.seq_number;
                v.status = ST_ACCEPT;
            end else begin
                gap = win_top - w.seq_number;
                if (gap >= WINDOW_SIZE || win_bits[gap[5:0]]) begin
                    replay_hits++;
                    v.status = ST_REPLAY;
                end else begin
                    win_bits[gap[5:0]] = 1'b1;
                    v.status = ST_ACCEPT;
                end
            end
            if (v.status == ST_ACCEPT) begin
                v.class_out      = w.traffic_class;
                v.payload_length = w.datagram_length - LEN_W'(MIN_LENGTH);
            end
        end
        v.auth_fail_count   = auth_fails;
        v.stale_epoch_count = stale_hits;
        v.replay_count      = replay_hits;
        return v;
    endfunction

    function automatic probe_row_t probe(input bit session, input logic [7:0] ep,
                                         input logic [31:0] seq, input bit fs, input bit fa,
                                         input logic [3:0] cls, input logic [11:0] len,
                                         input bit tag, input bit typed, input status_t st,
                                         input logic [31:0] full_ep);
        probe_row_t r;
        r.session              = session;
        r.word                 = '0;
        r.word.epoch_low       = ep;
        r.word.seq_number      = seq;
        r.word.flag_session    = fs;
        r.word.flag_auth       = fa;
        r.word.traffic_class   = cls;
        r.word.datagram_length = len;
        r.word.tag_ok          = tag;
        r.typed                = typed;
        r.status               = st;
        r.epoch                = full_ep;
        return r;
    endfunction

    // Mostly well-formed headers aimed at the live epoch and window, some noise.
    function automatic in_word_t random_datagram();
        in_word_t w;
        int       pick;
        w = '0;
        if ($urandom_range(99) < 15) begin
            w.epoch_low       = 8'($urandom);
            w.seq_number      = $urandom;
            w.flag_session    = 1'($urandom);
            w.flag_auth       = 1'($urandom);
            w.traffic_class   = 4'($urandom);
            w.datagram_length = LEN_W'($urandom);
            w.tag_ok          = 1'($urandom);
            return w;
        end
        w.flag_session  = 1'b1;
        w.flag_auth     = 1'b1;
        w.traffic_class = 4'($urandom);
        w.tag_ok        = ($urandom_range(99) < 90);
        pick = $urandom_range(99);
        if (pick < 10)
            w.datagram_length = LEN_W'(MIN_LENGTH);
        else if (pick < 20)
            w.datagram_length = LEN_W'(MAX_LENGTH);
        else
            w.datagram_length = LEN_W'($urandom_range(MAX_LENGTH, MIN_LENGTH));
        pick = $urandom_range(99);
        if (pick < 70)
            w.epoch_low = cur_epoch[7:0];
        else if (pick < 80)
            w.epoch_low = cur_epoch[7:0] + 8'($urandom_range(128, 1));
        else if (pick < 90)
            w.epoch_low = cur_epoch[7:0] - 8'($urandom_range(128, 1));
        else
            w.epoch_low = 8'($urandom);
        pick = $urandom_range(99);
        if (w.epoch_low != cur_epoch[7:0] || pick < 10)
            w.seq_number = $urandom;
        else if (pick < 50)
            w.seq_number = win_top + $urandom_range(70, 1);
        else
            w.seq_number = win_top - $urandom_range(70, 0);
        return w;
    endfunction

    task automatic offer_datagram(input in_word_t w, input bit typed, input status_t st,
                                  input logic [31:0] full_ep);
        out_word_t v;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (s_tready !== 1'b1);
        v = predict_verdict(w);
        if (typed) begin
            v.status     = st;
            v.full_epoch = full_ep;
        end
        verdict_q.push_back(v);
    endtask

    // Write the session register once every outstanding word is back.
    task automatic set_session(input bit on);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        session_on = on;
    endtask

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got_word = m_tdata;
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result word with nothing expected: %h", m_tdata);
            end else begin
                want_word = verdict_q.pop_front();
                if (got_word.status !== want_word.status ||
                    got_word.full_epoch !== want_word.full_epoch ||
                    got_word.epoch_adopted !== want_word.epoch_adopted ||
                    got_word.class_out !== want_word.class_out ||
                    got_word.payload_length !== want_word.payload_length ||
                    got_word.auth_fail_count !== want_word.auth_fail_count ||
                    got_word.stale_epoch_count !== want_word.stale_epoch_count ||
                    got_word.replay_count !== want_word.replay_count ||
                    got_word.pad !== want_word.pad) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch expected: st=%0d ep=%h ad=%0d cls=%h len=%0d af=%0d se=%0d rp=%0d",
                                 want_word.status, want_word.full_epoch, want_word.epoch_adopted,
                                 want_word.class_out, want_word.payload_length,
                                 want_word.auth_fail_count, want_word.stale_epoch_count,
                                 want_word.replay_count);
                        $display("         actual:   st=%0d ep=%h ad=%0d cls=%h len=%0d af=%0d se=%0d rp=%0d pad=%h",
                                 got_word.status, got_word.full_epoch, got_word.epoch_adopted,
                                 got_word.class_out, got_word.payload_length,
                                 got_word.auth_fail_count, got_word.stale_epoch_count,
                                 got_word.replay_count, got_word.pad);
                    end
                end
            end
        end
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_tvalid === 1'b1 && s_tready === 1'b1) ||
            (m_tvalid === 1'b1 && m_tready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        probe_row_t plan[$];
        phase_t     phases[4];
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;

        //                  sess ep     seq           fs fa cls   len       tag typed status      epoch
        plan.push_back(probe(0, 8'h00, 32'd1,        1, 1, 4'h5, 12'd100,  1, 1, ST_MALFORMED, 32'h0));
        plan.push_back(probe(0, 8'hFF, 32'hFFFFFFFF, 1, 1, 4'hF, 12'd4095, 1, 1, ST_MALFORMED, 32'h0));
        plan.push_back(probe(1, 8'h00, 32'd0,        1, 1, 4'h0, 12'd21,   1, 1, ST_MALFORMED, 32'h0));
        plan.push_back(probe(1, 8'h00, 32'd0,        1, 1, 4'h0, 12'd2049, 1, 1, ST_MALFORMED, 32'h0));
        plan.push_back(probe(1, 8'h00, 32'd0,        0, 1, 4'h0, 12'd0,    1, 1, ST_MALFORMED, 32'h0));
        plan.push_back(probe(1, 8'h00, 32'd0,        1, 0, 4'h0, 12'd100,  1, 1, ST_MALFORMED, 32'h0));
        plan.push_back(probe(1, 8'h00, 32'd0,        1, 1, 4'h0, 12'd22,   1, 0, ST_ACCEPT,    32'h0));
        plan.push_back(probe(1, 8'h00, 32'd0,        1, 1, 4'h0, 12'd22,   1, 1, ST_REPLAY,    32'h0));
        plan.push_back(probe(1, 8'h00, 32'd5,        1, 1, 4'hF, 12'd2048, 1, 0, ST_ACCEPT,    32'h0));
        plan.push_back(probe(1, 8'h00, 32'd3,        1, 1, 4'hA, 12'd64,   1, 0, ST_ACCEPT,    32'h0));
        plan.push_back(probe(1, 8'h00, 32'd3,        1, 1, 4'hA, 12'd64,   1, 1, ST_REPLAY,    32'h0));
        plan.push_back(probe(1, 8'h00, 32'd5,        1, 1, 4'h1, 12'd64,   0, 1, ST_AUTH_FAIL, 32'h0));
        // low byte far above the current one: wraps below epoch zero
        plan.push_back(probe(1, 8'hC8, 32'd7,        1, 1, 4'h2, 12'd64,   0, 1, ST_STALE,
                             32'hFFFFFFC8));
        plan.push_back(probe(1, 8'h80, 32'd9,        1, 1, 4'h3, 12'd64,   0, 1, ST_AUTH_FAIL, 32'h80));
        plan.push_back(probe(1, 8'h80, 32'd1000,     1, 1, 4'h4, 12'd300,  1, 0, ST_ACCEPT,    32'h0));
        plan.push_back(probe(1, 8'h00, 32'd1000,     1, 1, 4'h4, 12'd300,  1, 1, ST_STALE,     32'h0));
        plan.push_back(probe(1, 8'h01, 32'd1001,     1, 1, 4'h4, 12'd300,  1, 1, ST_STALE,     32'h1));
        plan.push_back(probe(1, 8'h80, 32'd936,      1, 1, 4'h6, 12'd300,  1, 1, ST_REPLAY,    32'h80));
        plan.push_back(probe(1, 8'h80, 32'd937,      1, 1, 4'h6, 12'd300,  1, 0, ST_ACCEPT,    32'h0));
        plan.push_back(probe(1, 8'h80, 32'd1100,     1, 1, 4'h7, 12'd500,  1, 0, ST_ACCEPT,    32'h0));
        plan.push_back(probe(1, 8'h80, 32'd1037,     1, 1, 4'h8, 12'd500,  1, 0, ST_ACCEPT,    32'h0));
        plan.push_back(probe(1, 8'hFF, 32'hFFFFFFFF, 1, 1, 4'h9, 12'd700,  1, 0, ST_ACCEPT,    32'h0));
        plan.push_back(probe(1, 8'h7F, 32'd0,        1, 1, 4'h9, 12'd700,  1, 1, ST_STALE,     32'h7F));
        plan.push_back(probe(1, 8'h7E, 32'd0,        1, 1, 4'hB, 12'd700,  1, 0, ST_ACCEPT,    32'h0));
        plan.push_back(probe(1, 8'h7E, 32'hFFFFFFFF, 1, 1, 4'hC, 12'd900,  1, 0, ST_ACCEPT,    32'h0));

        phases[0] = '{1'b1, 23, 65, 200};
        phases[1] = '{1'b0, 65, 23, 20};
        phases[2] = '{1'b1, 65, 23, 180};
        phases[3] = '{1'b1, 0, 0, 200};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_session(1'b0);

        foreach (plan[i]) begin
            if (plan[i].session != session_on)
                set_session(plan[i].session);
            offer_datagram(plan[i].word, plan[i].typed, plan[i].status, plan[i].epoch);
        end

        foreach (phases[p]) begin
            src_idle_pct = phases[p].src_idle;
            rcv_idle_pct = phases[p].rcv_idle;
            set_session(phases[p].session);
            repeat (phases[p].count)
                offer_datagram(random_datagram(), 1'b0, ST_ACCEPT, 32'h0);
        end

        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: epoch_anti_replay_window.f
+incdir+design
design/earw_pkg.sv
design/earw_epoch.sv
design/earw_window.sv
design/epoch_anti_replay_window.sv
dv/epoch_anti_replay_window_tb.sv
